// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [5:0] PLUS_VAL   = 6'h3E;
  localparam logic [5:0] SLASH_VAL  = 6'h3F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  // Alphabet lookup result: bad set when the character is outside the alphabet.
  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } sextet_t;

  // One request for the back end: up to three bytes, or one error result.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    status_t     status;
    logic        msg_end;
  } cmd_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.bad   = 1'b0;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PLUS_CHAR) begin
      s.value = PLUS_VAL;
    end else if (c == SLASH_CHAR) begin
      s.value = SLASH_VAL;
    end else if (c == PAD_CHAR) begin
      s.value = 6'd0;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/b64d_in_if.sv =====
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       message_end;

  modport source (output valid, output char_code, output message_end, input ready);
  modport sink   (input valid, input char_code, input message_end, output ready);
endinterface

// ===== rtl/b64d_out_if.sv =====
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       run_last;
  logic       message_last;

  modport source (output valid, output data_byte, output status, output run_last,
                  output message_last, input ready);
  modport sink   (input valid, input data_byte, input status, input run_last,
                  input message_last, output ready);
endinterface

// ===== rtl/b64d_front.sv =====
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_if,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        discard_r, discard_nxt;
  logic        accept;
  logic        is_pad;
  sextet_t     sx;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign sx          = sextet_of(in_if.char_code);
  assign is_pad      = (in_if.char_code == PAD_CHAR);

  always_comb begin
    acc_nxt        = acc_r;
    pos_nxt        = pos_r;
    third_pad_nxt  = third_pad_r;
    discard_nxt    = discard_r;
    q_push         = 1'b0;
    q_data.word    = 24'd0;
    q_data.count   = 2'd1;
    q_data.status  = ST_OK;
    q_data.msg_end = 1'b1;
    if (accept) begin
      if (discard_r) begin
        // drop everything up to the end flag
        if (in_if.message_end) begin
          discard_nxt   = 1'b0;
          acc_nxt       = 18'd0;
          pos_nxt       = 2'd0;
          third_pad_nxt = 1'b0;
        end
      end else if (in_if.message_end && pos_r != 2'd3) begin
        acc_nxt       = 18'd0;
        pos_nxt       = 2'd0;
        third_pad_nxt = 1'b0;
        q_push        = 1'b1;
        q_data.status = ST_BAD_LEN;
      end else if (sx.bad) begin
        acc_nxt       = 18'd0;
        pos_nxt       = 2'd0;
        third_pad_nxt = 1'b0;
        discard_nxt   = !in_if.message_end;
        q_push        = 1'b1;
        q_data.status = ST_BAD_CHAR;
      end else if (pos_r != 2'd3) begin
        if (pos_r == 2'd2) begin
          third_pad_nxt = is_pad;
        end
        acc_nxt = {acc_r[11:0], sx.value};
        pos_nxt = pos_r + 2'd1;
      end else begin
        q_push         = 1'b1;
        q_data.word    = {acc_r, sx.value};
        q_data.msg_end = in_if.message_end;
        q_data.count   = 2'd3;
        if (in_if.message_end) begin
          if (third_pad_r) begin
            q_data.count = 2'd1;
          end else if (is_pad) begin
            q_data.count = 2'd2;
          end
        end
        acc_nxt       = 18'd0;
        pos_nxt       = 2'd0;
        third_pad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 18'd0;
      pos_r       <= 2'd0;
      third_pad_r <= 1'b0;
      discard_r   <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      third_pad_r <= third_pad_nxt;
      discard_r   <= discard_nxt;
    end
  end

endmodule

// ===== rtl/b64d_fifo.sv =====
module b64d_fifo import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  b64d_out_if.source out_if
);

  cmd_t       cmd_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take, last, load;

  assign take  = busy_r && out_if.ready;
  assign last  = (idx_r == cmd_r.count - 2'd1);
  assign load  = !busy_r || (take && last);
  assign q_pop = load && !q_empty;

  assign out_if.valid        = busy_r;
  assign out_if.status       = cmd_r.status;
  assign out_if.run_last     = last;
  assign out_if.message_last = last && cmd_r.msg_end;

  always_comb begin
    case (idx_r)
      2'd0:    out_if.data_byte = cmd_r.word[23:16];
      2'd1:    out_if.data_byte = cmd_r.word[15:8];
      2'd2:    out_if.data_byte = cmd_r.word[7:0];
      default: out_if.data_byte = 8'd0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (take && last) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
  end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Channel | Dir | Payload                                   | Moves per request
// in_if   | in  | char_code[7:0], message_end               | one Base64 character
// out_if  | out | data_byte[7:0], status[1:0], run_last,    | one byte or one error
//         |     | message_last                              |
//
// Takes one character per cycle while the command queue has room.
// Emits one result per cycle while out_if.ready is high; a quad gives up to
// three bytes, an error one result. The command queue (QUEUE_DEPTH entries)
// sets how long the input side rides out a stalled output before in_if.ready drops.
// Synchronous active-low reset clears quad state, discard flag, queue and output.
// The first result of a quad is written into the queue and then loaded into the
// output register before it can be taken; a busy output holds it in the queue.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_if,
  b64d_out_if.source out_if
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  // Front end: classify each character, gather quads, queue byte or error requests.
  b64d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Decouple the two sides so a stalled output does not block input right away.
  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back end: hold one request and serialize its bytes onto the output.
  b64d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full command queue");

  // Error results carry zero data and close the message.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_OK) |->
      (out_if.data_byte == 8'd0 && out_if.run_last && out_if.message_last))
    else $error("malformed error result");

  // The last result of a message is also the last of its request.
  a_msg_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.message_last) |-> out_if.run_last)
    else $error("message_last without run_last");

  // A popped request always comes out on the next cycle.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_if.valid)
    else $error("popped request not presented");

endmodule
